FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL files of the UUID generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define UUIDG_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) else $error(msg);

// Condition that must be followed by a consequence at the next edge.
`define UUIDG_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/uuidg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUID generator package
// Shared request codes, constants and the queue item type.
// ----------------------------------------------------------------------------
package uuidg_pkg;

  // Requested UUID kind.
  localparam logic [1:0] OP_V1 = 2'd0;
  localparam logic [1:0] OP_V6 = 2'd1;
  localparam logic [1:0] OP_V4 = 2'd2;
  localparam logic [1:0] OP_V7 = 2'd3;

  // Ticks between 1582-10-15 and the Unix epoch, in 100 ns units.
  localparam logic [59:0] EPOCH_OFFSET = 60'h1B21DD213814000;
  // Ticks per millisecond.
  localparam logic [13:0] MSEC_TICKS = 14'd10000;
  // Division by 100 of a 14-bit value: (x * 5243) >> 19 is exact there.
  localparam logic [12:0] NS_DIV_MUL = 13'd5243;
  localparam int NS_DIV_SHIFT = 19;

  // Version nibbles and the RFC variant bits.
  localparam logic [3:0] VER_1 = 4'h1;
  localparam logic [3:0] VER_6 = 4'h6;
  localparam logic [3:0] VER_4 = 4'h4;
  localparam logic [3:0] VER_7 = 4'h7;
  localparam logic [1:0] VARIANT = 2'b10;

  // Default queue depths.
  localparam int QUEUE_DEPTH = 2;
  localparam int RESULT_DEPTH = 2;

  // Item passed from the front end to the back end.
  typedef struct packed {
    logic [1:0]  op;
    logic        custom;
    logic [59:0] now_ticks;
    logic [59:0] tick_prod;
    logic [7:0]  ns_quot;
    logic        use_clockseq;
    logic [13:0] clockseq_value;
    logic        use_node;
    logic [47:0] node_value;
    logic [63:0] fmt_high;
    logic [63:0] fmt_low;
  } entry_t;

  // Per-version generator state.
  typedef struct packed {
    logic        ready;
    logic [59:0] last_time;
    logic [13:0] seq_num;
    logic [47:0] node;
  } time_state_t;

endpackage

FILE: src/time_based_uuid_generator.sv
`timescale 1ns / 1ps
// An accepted item passes from the request queue through the back end into the
// result queue, from which it can be popped.
// Throughput: one item per cycle while the result queue is not full; the v1/v6
// state update in the back end is one 60-bit compare and increment.
// A two-entry queue parts front and back, a two-entry result queue the output.
// Reset: synchronous, active high; clears v1/v6 state, both queues, and
// loads the seed registers with their defaults.
// ----------------------------------------------------------------------------
// Time-based UUID generator
// Produces version 1, 6, 4 and 7 UUIDs, one per request.
// ----------------------------------------------------------------------------
module time_based_uuid_generator #(
  parameter int QUEUE_DEPTH  = uuidg_pkg::QUEUE_DEPTH,
  parameter int RESULT_DEPTH = uuidg_pkg::RESULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // Request side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op,
  input  logic [59:0] now_ticks,
  input  logic [47:0] now_msecs,
  input  logic        use_custom_time,
  input  logic [47:0] caller_msecs,
  input  logic [13:0] caller_nsecs,
  input  logic        use_clockseq,
  input  logic [13:0] clockseq_value,
  input  logic        use_node,
  input  logic [47:0] node_value,
  input  logic [63:0] random_high,
  input  logic [63:0] random_low,
  // Result side
  input  logic        pop,
  output logic        empty,
  output logic [63:0] uuid_high,
  output logic [63:0] uuid_low
);
  import uuidg_pkg::*;

  localparam int EntryW = $bits(entry_t);

  logic [47:0]  node_seed;
  logic [13:0]  clock_seq_seed;
  logic         cfg_write;
  entry_t       front_entry;
  entry_t       back_entry;
  logic         q_empty;
  logic         back_take;
  logic         res_full;
  logic [63:0]  res_high;
  logic [63:0]  res_low;
  logic [127:0] res_dout;

  // Configuration registers: node seed at 0, clock sequence seed at 8.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = paddr[3] ? {50'd0, clock_seq_seed} : {16'd0, node_seed};

  always_ff @(posedge clk) begin
    if (rst) begin
      node_seed      <= 48'h010000000000;
      clock_seq_seed <= '0;
    end else if (cfg_write) begin
      if (paddr[3]) begin
        clock_seq_seed <= pwdata[13:0];
      end else begin
        node_seed <= pwdata[47:0];
      end
    end
  end

  // Front end: classify and precompute.
  uuidg_front u_front (
    .op              (op),
    .now_ticks       (now_ticks),
    .now_msecs       (now_msecs),
    .use_custom_time (use_custom_time),
    .caller_msecs    (caller_msecs),
    .caller_nsecs    (caller_nsecs),
    .use_clockseq    (use_clockseq),
    .clockseq_value  (clockseq_value),
    .use_node        (use_node),
    .node_value      (node_value),
    .random_high     (random_high),
    .random_low      (random_low),
    .entry           (front_entry)
  );

  // Queue between front and back.
  uuidg_fifo #(
    .Width (EntryW),
    .Depth (QUEUE_DEPTH)
  ) u_req_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_entry),
    .full  (full),
    .pop   (back_take),
    .dout  (back_entry),
    .empty (q_empty)
  );

  // Back end: state and formatting.
  uuidg_back u_back (
    .clk            (clk),
    .rst            (rst),
    .node_seed      (node_seed),
    .clock_seq_seed (clock_seq_seed),
    .in_valid       (!q_empty),
    .in_entry       (back_entry),
    .in_take        (back_take),
    .out_full       (res_full),
    .res_high       (res_high),
    .res_low        (res_low)
  );

  // Result queue toward the consumer.
  uuidg_fifo #(
    .Width (128),
    .Depth (RESULT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (back_take),
    .din   ({res_high, res_low}),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  assign uuid_high = res_dout[127:64];
  assign uuid_low  = res_dout[63:0];

endmodule

FILE: src/uuidg_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUID generator queue
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uuidg_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] dout,
  output logic             empty
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  logic [Width-1:0] mem [Depth];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // Storage is written without reset; only the pointers and the count are control state.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers wrap at the depth, the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `UUIDG_ASSERT(a_count_bound, clk, rst, count <= CW'(Depth), "queue count above depth")
  `UUIDG_ASSERT_NEXT(a_push_grows, clk, rst, do_push && !do_pop, count == $past(count) + 1'b1, "queue count did not grow on push")
  `UUIDG_ASSERT(a_full_empty, clk, rst, !(full && empty), "queue full and empty at once")

endmodule

FILE: src/uuidg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUID generator front end
// Classifies each request, forms the random-based UUIDs and prepares the
// custom-time products for the back end.
// ----------------------------------------------------------------------------
module uuidg_front (
  input  logic              [1:0]  op,
  input  logic              [59:0] now_ticks,
  input  logic              [47:0] now_msecs,
  input  logic                     use_custom_time,
  input  logic              [47:0] caller_msecs,
  input  logic              [13:0] caller_nsecs,
  input  logic                     use_clockseq,
  input  logic              [13:0] clockseq_value,
  input  logic                     use_node,
  input  logic              [47:0] node_value,
  input  logic              [63:0] random_high,
  input  logic              [63:0] random_low,
  output uuidg_pkg::entry_t        entry
);
  import uuidg_pkg::*;

  logic [61:0] ms_prod;
  logic [26:0] ns_prod;
  logic [47:0] v7_msecs;

  // Custom time: milliseconds to ticks, nanoseconds divided by 100.
  assign ms_prod  = caller_msecs * MSEC_TICKS;
  assign ns_prod  = caller_nsecs * NS_DIV_MUL;
  assign v7_msecs = use_custom_time ? caller_msecs : now_msecs;

  // Pack the item; random kinds are finished here.
  always_comb begin
    entry                = '0;
    entry.op             = op;
    entry.custom         = use_custom_time;
    entry.now_ticks      = now_ticks;
    entry.tick_prod      = ms_prod[59:0];
    entry.ns_quot        = ns_prod[NS_DIV_SHIFT +: 8];
    entry.use_clockseq   = use_clockseq;
    entry.clockseq_value = clockseq_value;
    entry.use_node       = use_node;
    entry.node_value     = node_value;
    entry.fmt_low        = {VARIANT, random_low[61:0]};
    unique case (op)
      OP_V4: entry.fmt_high = {random_high[63:16], VER_4, random_high[11:0]};
      OP_V7: entry.fmt_high = {v7_msecs, VER_7, random_high[11:0]};
      default: entry.fmt_high = '0;
    endcase
  end

endmodule

FILE: src/uuidg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUID generator back end
// Holds the v1 and v6 state, applies overrides and the monotonic rule, and
// formats the time-based UUIDs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uuidg_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic              [47:0] node_seed,
  input  logic              [13:0] clock_seq_seed,
  input  logic                     in_valid,
  input  uuidg_pkg::entry_t        in_entry,
  output logic                     in_take,
  input  logic                     out_full,
  output logic              [63:0] res_high,
  output logic              [63:0] res_low
);
  import uuidg_pkg::*;

  time_state_t v1_st;
  time_state_t v6_st;
  time_state_t cur;
  time_state_t upd;
  logic        is_time;
  logic        sel_v6;
  logic        plain;
  logic [59:0] ts_custom;
  logic [59:0] ts_in;
  logic [59:0] ts;
  logic [13:0] seq_base;

  assign in_take = in_valid && !out_full;
  assign is_time = (in_entry.op == OP_V1) || (in_entry.op == OP_V6);
  assign sel_v6  = (in_entry.op == OP_V6);
  assign plain   = !in_entry.custom && !in_entry.use_clockseq;
  assign cur     = sel_v6 ? v6_st : v1_st;

  // Custom timestamp wraps modulo 2^60.
  assign ts_custom = in_entry.tick_prod + EPOCH_OFFSET + {52'd0, in_entry.ns_quot};
  assign ts_in     = in_entry.custom ? ts_custom : in_entry.now_ticks;

  // Seed on first use, then overrides, then the monotonic fix.
  always_comb begin
    upd       = cur;
    upd.ready = 1'b1;
    if (!cur.ready) begin
      upd.node = {node_seed[47:41], 1'b1, node_seed[39:0]};
    end
    seq_base = cur.ready ? cur.seq_num : clock_seq_seed;
    if (in_entry.use_node) begin
      upd.node = in_entry.node_value;
    end
    upd.seq_num = in_entry.use_clockseq ? in_entry.clockseq_value : seq_base;
    ts = ts_in;
    if (plain) begin
      if (ts_in <= cur.last_time) begin
        ts          = cur.last_time + 1'b1;
        upd.seq_num = seq_base + 1'b1;
      end
      upd.last_time = ts;
    end
  end

  // Result formatting for every kind.
  always_comb begin
    res_low = in_entry.fmt_low;
    unique case (in_entry.op)
      OP_V1: begin
        res_high = {ts[31:0], ts[47:32], VER_1, ts[59:48]};
        res_low  = {VARIANT, upd.seq_num, upd.node};
      end
      OP_V6: begin
        res_high = {ts[59:12], VER_6, ts[11:0]};
        res_low  = {VARIANT, upd.seq_num, upd.node};
      end
      default: res_high = in_entry.fmt_high;
    endcase
  end

  // State of the selected version is updated when an item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1_st <= '0;
      v6_st <= '0;
    end else if (in_take && is_time) begin
      if (sel_v6) begin
        v6_st <= upd;
      end else begin
        v1_st <= upd;
      end
    end
  end

  `UUIDG_ASSERT_NEXT(a_v1_time_moves, clk, rst, in_take && (in_entry.op == OP_V1) && plain, v1_st.last_time != $past(v1_st.last_time), "v1 timestamp did not advance")
  `UUIDG_ASSERT_NEXT(a_v6_time_moves, clk, rst, in_take && (in_entry.op == OP_V6) && plain, v6_st.last_time != $past(v6_st.last_time), "v6 timestamp did not advance")
  `UUIDG_ASSERT(a_v1_ready_holds, clk, rst, !$fell(v1_st.ready) || $past(rst), "v1 state lost its ready flag")

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-based UUID generator testbench
// Sends version 1, 6, 4 and 7 requests through the push/full side, forecasts
// every UUID with an independent model of the per-version clock state, and
// compares each popped result in order. Seeds are written over the APB port
// while the block is idle, and both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import uuidg_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 480;
  localparam logic [3:0] ADDR_NODE_SEED = 4'd0;
  localparam logic [3:0] ADDR_CLOCK_SEQ_SEED = 4'd8;
  localparam logic [47:0] MULTICAST_BIT = 48'h0100_0000_0000;
  localparam logic [59:0] TICKS_MAX = 60'hFFF_FFFF_FFFF_FFFF;
  localparam logic [47:0] MSECS_MAX = 48'hFFFF_FFFF_FFFF;

  // One request as it sits on the input ports.
  typedef struct packed {
    logic [1:0]  op;
    logic [59:0] now_ticks;
    logic [47:0] now_msecs;
    logic        use_custom_time;
    logic [47:0] caller_msecs;
    logic [13:0] caller_nsecs;
    logic        use_clockseq;
    logic [13:0] clockseq_value;
    logic        use_node;
    logic [47:0] node_value;
    logic [63:0] random_high;
    logic [63:0] random_low;
  } uuid_request_t;

  typedef struct packed {
    logic [63:0] hi_word;
    logic [63:0] lo_word;
  } uuid_value_t;

  // Clock state kept separately for version 1 and version 6.
  typedef struct packed {
    logic        ready;
    logic [59:0] last_time;
    logic [13:0] seq_count;
    logic [47:0] node;
  } clock_track_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;
  logic push;
  logic full;
  logic pop;
  logic empty;
  logic [63:0] uuid_high;
  logic [63:0] uuid_low;
  uuid_request_t req_drive;

  // Forecast state and the UUIDs still waiting to come out.
  clock_track_t v1_track;
  clock_track_t v6_track;
  logic [47:0] node_seed_q;
  logic [13:0] clock_seq_q;
  logic [59:0] tick_cursor;
  uuid_value_t pending_uuids[$];

  bit gaps_on;
  int holdoff_asked;
  int cycle_count;
  int mismatch_count;
  int results_checked;
  int full_stalls;
  int kind_count[4];
  int custom_count;
  int clockseq_count;
  int node_count;

  time_based_uuid_generator uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .push(push),
    .full(full),
    .op(req_drive.op),
    .now_ticks(req_drive.now_ticks),
    .now_msecs(req_drive.now_msecs),
    .use_custom_time(req_drive.use_custom_time),
    .caller_msecs(req_drive.caller_msecs),
    .caller_nsecs(req_drive.caller_nsecs),
    .use_clockseq(req_drive.use_clockseq),
    .clockseq_value(req_drive.clockseq_value),
    .use_node(req_drive.use_node),
    .node_value(req_drive.node_value),
    .random_high(req_drive.random_high),
    .random_low(req_drive.random_low),
    .pop(pop),
    .empty(empty),
    .uuid_high(uuid_high),
    .uuid_low(uuid_low)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on) return 0;
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Works out the timestamp of a v1/v6 request and updates that clock state.
  task automatic stamp_time(inout clock_track_t st, input uuid_request_t r,
                            output logic [59:0] ts);
    logic [63:0] wide;
    if (!st.ready) begin
      st.node = node_seed_q | MULTICAST_BIT;
      st.seq_count = clock_seq_q;
      st.ready = 1'b1;
    end
    if (r.use_node) st.node = r.node_value;
    if (r.use_clockseq) st.seq_count = r.clockseq_value;
    if (r.use_custom_time) begin
      wide = {16'd0, r.caller_msecs} * {50'd0, MSEC_TICKS} + {4'd0, EPOCH_OFFSET}
           + {50'd0, r.caller_nsecs / 14'd100};
      ts = wide[59:0];
    end else begin
      ts = r.now_ticks;
    end
    // Plain requests must move time forward; a repeat bumps the sequence.
    if (!r.use_custom_time && !r.use_clockseq) begin
      if (ts <= st.last_time) begin
        ts = st.last_time + 60'd1;
        st.seq_count = st.seq_count + 14'd1;
      end
      st.last_time = ts;
    end
  endtask

  task automatic forecast_uuid(input uuid_request_t r, output uuid_value_t u);
    logic [59:0] ts;
    logic [47:0] ms;
    case (r.op)
      OP_V1: begin
        stamp_time(v1_track, r, ts);
        u.hi_word = {ts[31:0], ts[47:32], VER_1, ts[59:48]};
        u.lo_word = {VARIANT, v1_track.seq_count, v1_track.node};
      end
      OP_V6: begin
        stamp_time(v6_track, r, ts);
        u.hi_word = {ts[59:12], VER_6, ts[11:0]};
        u.lo_word = {VARIANT, v6_track.seq_count, v6_track.node};
      end
      OP_V4: begin
        u.hi_word = {r.random_high[63:16], VER_4, r.random_high[11:0]};
        u.lo_word = {VARIANT, r.random_low[61:0]};
      end
      default: begin
        ms = r.use_custom_time ? r.caller_msecs : r.now_msecs;
        u.hi_word = {ms, VER_7, r.random_high[11:0]};
        u.lo_word = {VARIANT, r.random_low[61:0]};
      end
    endcase
  endtask

  function automatic uuid_request_t blank_request(input logic [1:0] kind);
    uuid_request_t r;
    r = '0;
    r.op = kind;
    return r;
  endfunction

  // Random request: time mostly creeps forward, with repeats, steps back,
  // jumps and values near the top of the 60-bit range.
  function automatic uuid_request_t random_request();
    uuid_request_t r;
    logic [63:0] w;
    int roll;
    r.op = 2'($urandom_range(0, 3));
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      tick_cursor = tick_cursor + 60'($urandom_range(0, 3));
    end else if (roll < 80) begin
      tick_cursor = tick_cursor - 60'($urandom_range(0, 50));
    end else if (roll < 90) begin
      w = rand64();
      tick_cursor = w[59:0];
    end else begin
      tick_cursor = TICKS_MAX - 60'($urandom_range(0, 3));
    end
    r.now_ticks = tick_cursor;
    w = rand64();
    r.now_msecs = w[47:0];
    r.use_custom_time = ($urandom_range(0, 99) < 15);
    w = rand64();
    r.caller_msecs = ($urandom_range(0, 9) == 0) ? MSECS_MAX : w[47:0];
    r.caller_nsecs = 14'($urandom_range(0, 16383));
    r.use_clockseq = ($urandom_range(0, 99) < 10);
    r.clockseq_value = 14'($urandom_range(0, 16383));
    r.use_node = ($urandom_range(0, 99) < 10);
    w = rand64();
    r.node_value = w[47:0];
    r.random_high = rand64();
    r.random_low = rand64();
    return r;
  endfunction

  // Offers one item and forecasts its UUID at the edge that takes it.
  task automatic send_item(input uuid_request_t r);
    int gap;
    uuid_value_t want;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    req_drive = r;
    push = 1'b1;
    @(posedge clk);
    while (full) begin
      full_stalls++;
      @(posedge clk);
    end
    forecast_uuid(r, want);
    pending_uuids.push_back(want);
    kind_count[r.op]++;
    if (r.use_custom_time) custom_count++;
    if (r.use_clockseq) clockseq_count++;
    if (r.use_node) node_count++;
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_uuids.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_register(input logic [3:0] addr, input logic [63:0] value);
    wait_idle();
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_NODE_SEED) node_seed_q = value[47:0];
    else if (addr == ADDR_CLOCK_SEQ_SEED) clock_seq_q = value[13:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s mismatch: expected %h, got %h", what, want, got);
  endtask

  // Result checker: every popped UUID against the oldest forecast.
  always @(posedge clk) begin
    uuid_value_t want;
    if (!rst && pop && !empty) begin
      results_checked++;
      if (pending_uuids.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result %h_%h with nothing pending", uuid_high, uuid_low);
      end else begin
        want = pending_uuids.pop_front();
        if (uuid_high !== want.hi_word) note_mismatch("uuid_high", want.hi_word, uuid_high);
        if (uuid_low !== want.lo_word) note_mismatch("uuid_low", want.lo_word, uuid_low);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  initial begin
    int stall_left;
    int hold_left;
    int holdoff_taken;
    stall_left = 0;
    hold_left = 0;
    holdoff_taken = 0;
    pop = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      @(negedge clk);
      if (holdoff_taken != holdoff_asked) begin
        hold_left = HOLD_CYCLES;
        holdoff_taken = holdoff_asked;
      end
      if (hold_left > 0) begin
        pop = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        pop = 1'b0;
        stall_left--;
      end else begin
        pop = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // First v1 and v6 requests pick up the seeds; time wraps at the top.
  task automatic test_first_requests();
    uuid_request_t r;
    // Upper junk bits must be dropped, and the multicast bit forced on.
    write_register(ADDR_NODE_SEED, 64'hABCD_0000_0000_0000);
    write_register(ADDR_CLOCK_SEQ_SEED, 64'h3FFF);
    r = blank_request(OP_V1);
    send_item(r);
    r.now_ticks = TICKS_MAX;
    send_item(r);
    r.now_ticks = 60'd7;
    send_item(r);
    // Only the version 6 state has not loaded its seeds yet.
    write_register(ADDR_NODE_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(ADDR_CLOCK_SEQ_SEED, 64'h0);
    r = blank_request(OP_V6);
    r.now_ticks = TICKS_MAX;
    send_item(r);
    send_item(r);
    r.now_ticks = 60'd0;
    send_item(r);
  endtask

  // Custom time, clock sequence and node overrides on both versions.
  task automatic test_overrides();
    uuid_request_t r;
    r = blank_request(OP_V1);
    r.use_custom_time = 1'b1;
    r.caller_msecs = MSECS_MAX;
    r.caller_nsecs = 14'h3FFF;
    send_item(r);
    r.caller_msecs = 48'd0;
    r.caller_nsecs = 14'd99;
    send_item(r);
    r = blank_request(OP_V1);
    r.now_ticks = 60'd100;
    r.use_clockseq = 1'b1;
    r.clockseq_value = 14'h3FFF;
    send_item(r);
    r = blank_request(OP_V1);
    r.now_ticks = 60'd200;
    r.use_node = 1'b1;
    r.node_value = MSECS_MAX;
    send_item(r);
    r.use_node = 1'b1;
    r.node_value = 48'd0;
    r.use_clockseq = 1'b1;
    r.clockseq_value = 14'd0;
    r.use_custom_time = 1'b1;
    r.caller_msecs = 48'd1;
    send_item(r);
    r = blank_request(OP_V6);
    r.use_custom_time = 1'b1;
    r.caller_nsecs = 14'd100;
    send_item(r);
    r = blank_request(OP_V6);
    r.now_ticks = 60'h123_4567_89AB_CDEF;
    r.use_node = 1'b1;
    r.node_value = 48'h5555_AAAA_5555;
    send_item(r);
    r.use_custom_time = 1'b1;
    r.caller_msecs = 48'hAAAA_5555_AAAA;
    r.caller_nsecs = 14'h2AAA;
    r.use_clockseq = 1'b1;
    r.clockseq_value = 14'h1555;
    send_item(r);
  endtask

  // Random kinds: version bits and variant only; v1/v6 state stays put.
  task automatic test_random_kinds();
    uuid_request_t r;
    r = blank_request(OP_V4);
    r.random_high = '1;
    r.random_low = '1;
    send_item(r);
    r = blank_request(OP_V4);
    r.use_node = 1'b1;
    r.node_value = MSECS_MAX;
    r.use_clockseq = 1'b1;
    r.clockseq_value = 14'h3FFF;
    r.now_ticks = TICKS_MAX;
    send_item(r);
    r = blank_request(OP_V7);
    r.now_msecs = MSECS_MAX;
    r.random_high = '1;
    r.random_low = '1;
    send_item(r);
    r = blank_request(OP_V7);
    r.use_custom_time = 1'b1;
    r.caller_msecs = MSECS_MAX;
    r.caller_nsecs = 14'h3FFF;
    send_item(r);
    send_item(blank_request(OP_V7));
    r = blank_request(OP_V1);
    r.now_ticks = 60'd1000;
    send_item(r);
  endtask

  // The receiver holds off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    holdoff_asked++;
    repeat (24) send_item(random_request());
    gaps_on = 1'b1;
  endtask

  // Long random run in phases; seeds rewritten between phases have no effect
  // until a reset, which never comes.
  task automatic test_random_mix();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_register(ADDR_NODE_SEED, 64'h0);
          write_register(ADDR_CLOCK_SEQ_SEED, 64'h0);
        end
        1: begin
          write_register(ADDR_NODE_SEED, '1);
          write_register(ADDR_CLOCK_SEQ_SEED, '1);
        end
        default: begin
          write_register(ADDR_NODE_SEED, rand64());
          write_register(ADDR_CLOCK_SEQ_SEED, rand64());
        end
      endcase
      gaps_on = (phase != 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase >= 2 && i % 120 == 0) gaps_on = ($urandom_range(0, 2) != 0);
        send_item(random_request());
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_drive = '0;
    v1_track = '0;
    v6_track = '0;
    node_seed_q = MULTICAST_BIT;
    clock_seq_q = '0;
    tick_cursor = '0;
    gaps_on = 1'b1;
    holdoff_asked = 0;
    mismatch_count = 0;
    results_checked = 0;
    full_stalls = 0;
    custom_count = 0;
    clockseq_count = 0;
    node_count = 0;
    for (int k = 0; k < 4; k++) kind_count[k] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_first_requests();
    test_overrides();
    test_random_kinds();
    test_backpressure();
    test_random_mix();

    // Drain, then give the block a few more cycles to show any stray result.
    while (pending_uuids.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d UUIDs: %0d v1, %0d v6, %0d v4, %0d v7; %0d input stall cycles.",
             results_checked, kind_count[OP_V1], kind_count[OP_V6], kind_count[OP_V4],
             kind_count[OP_V7], full_stalls);
    $display("Requests with custom time: %0d, clock sequence override: %0d, node: %0d.",
             custom_count, clockseq_count, node_count);
    if (mismatch_count == 0 && pending_uuids.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("testbench failed");
    end
    $finish;
  end

endmodule
